>>> sv/psod_pkg.sv
// Shared constants, types and the control-word program of the packet size outlier detector.
package psod_pkg;

  // Window depth, field widths and the widths that follow from them.
  localparam int WINDOW     = 100;
  localparam int IPVER_W    = 4;
  localparam int IPADDR_W   = 32;
  localparam int LEN_W      = 16;
  localparam int K_W        = 4;
  localparam int K2_W       = 2 * K_W;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int PTR_W      = $clog2(WINDOW);
  localparam int SUM_W      = LEN_W + CNT_W;
  localparam int SQ_W       = 2 * LEN_W + CNT_W;
  localparam int VAR_W      = 2 * SUM_W;
  localparam int P_W        = VAR_W + K2_W;
  localparam int MUL_A_W    = VAR_W;
  localparam int MUL_B_W    = SUM_W;
  localparam int MUL_W      = MUL_A_W + MUL_B_W;

  localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(WINDOW);
  localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(WINDOW - 1);
  localparam logic [IPVER_W-1:0] IPV4       = IPVER_W'(4);

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_OVERSIZE_LIMIT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SIGMA          = REG_IDX_W'(1);
  localparam logic [LEN_W-1:0]     LIMIT_RESET        = LEN_W'(1500);
  localparam logic [K_W-1:0]       SIGMA_RESET        = K_W'(2);

  // Operand pairs steered into the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LEN_LEN,
    MUL_OLD_OLD,
    MUL_N_LEN,
    MUL_N_Q,
    MUL_S_S,
    MUL_DEV_DEV,
    MUL_K_K,
    MUL_K2_VAR
  } mul_sel_t;

  // What the step does with the product of the previous step.
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_ADD_SQ,
    ACC_SUB_SQ,
    ACC_DEV,
    ACC_LOAD_T,
    ACC_SUB_T,
    ACC_LOAD_L,
    ACC_CMP
  } acc_op_t;

  // Sequencing: advance, or finish once the result register is free.
  typedef enum logic [0:0] {
    SEQ_NEXT,
    SEQ_END
  } seq_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     ram_rd;
    logic     commit;
    seq_t     seq;
  } ctrl_word_t;

  typedef struct packed {
    logic out_free;
    logic window_full;
  } status_t;

  localparam ctrl_word_t CTRL_NOP = '{
    mul_sel: MUL_NONE, acc_op: ACC_NONE, ram_rd: 1'b0, commit: 1'b0, seq: SEQ_NEXT
  };

  // Program steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_READ   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_COMMIT = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_EVICT  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_DEV    = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_NQ     = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_VAR    = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_LHS    = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_RHS    = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_DECIDE = STEP_W'(8);

  // Control store. Each step but decide starts a product; each but read uses the one before it.
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = CTRL_NOP;
    unique case (step)
      STEP_READ: begin
        w.mul_sel = MUL_LEN_LEN;
        w.ram_rd  = 1'b1;
      end
      STEP_COMMIT: begin
        w.mul_sel = MUL_OLD_OLD;
        w.acc_op  = ACC_ADD_SQ;
        w.commit  = 1'b1;
      end
      STEP_EVICT: begin
        w.mul_sel = MUL_N_LEN;
        w.acc_op  = ACC_SUB_SQ;
      end
      STEP_DEV: begin
        w.mul_sel = MUL_N_Q;
        w.acc_op  = ACC_DEV;
      end
      STEP_NQ: begin
        w.mul_sel = MUL_S_S;
        w.acc_op  = ACC_LOAD_T;
      end
      STEP_VAR: begin
        w.mul_sel = MUL_DEV_DEV;
        w.acc_op  = ACC_SUB_T;
      end
      STEP_LHS: begin
        w.mul_sel = MUL_K_K;
        w.acc_op  = ACC_LOAD_L;
      end
      STEP_RHS: begin
        w.mul_sel = MUL_K2_VAR;
      end
      STEP_DECIDE: begin
        w.acc_op = ACC_CMP;
        w.seq    = SEQ_END;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/psod_in_if.sv
// Packet word channel: valid, ready and the packet header fields.
interface psod_in_if;
  import psod_pkg::*;

  logic                valid;
  logic                ready;
  logic [IPVER_W-1:0]  ip_version;
  logic [IPADDR_W-1:0] src_address;
  logic [IPADDR_W-1:0] dst_address;
  logic [LEN_W-1:0]    packet_length;

  modport source (
    output valid, ip_version, src_address, dst_address, packet_length,
    input  ready
  );

  modport sink (
    input  valid, ip_version, src_address, dst_address, packet_length,
    output ready
  );

endinterface

>>> sv/psod_out_if.sv
// Result word channel: valid, ready and the three packet flags.
interface psod_out_if;

  logic valid;
  logic ready;
  logic same_address;
  logic oversize;
  logic outlier;

  modport source (
    output valid, same_address, oversize, outlier,
    input  ready
  );

  modport sink (
    input  valid, same_address, oversize, outlier,
    output ready
  );

endinterface

>>> sv/psod_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module psod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/psod_ucode.sv
// Sequencer: step counter, control store lookup and end-of-program handling.
module psod_ucode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  psod_pkg::status_t     status,
  output psod_pkg::ctrl_word_t  ctrl,
  output logic                  busy
);
  import psod_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;

  // Control word of the current step; idle cycles issue no operation.
  always_comb begin
    ctrl = busy_r ? ucode_rom(step_r) : CTRL_NOP;
  end

  // Step counter: start on a new word, advance, or leave the program once the result is stored.
  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = STEP_READ;
      end
    end else begin
      unique case (ctrl.seq)
        SEQ_NEXT: begin
          step_nxt = step_r + STEP_W'(1);
        end
        SEQ_END: begin
          if (status.out_free) begin
            busy_nxt = 1'b0;
            step_nxt = STEP_READ;
          end
        end
        default: begin
          step_nxt = step_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_READ;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> sv/psod_datapath.sv
// Datapath: length ring, running sums, shared multiplier and the result register.
module psod_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [psod_pkg::IPADDR_W-1:0]  src_address,
  input  logic [psod_pkg::IPADDR_W-1:0]  dst_address,
  input  logic [psod_pkg::LEN_W-1:0]     packet_length,
  input  logic [psod_pkg::LEN_W-1:0]     oversize_limit,
  input  logic [psod_pkg::K_W-1:0]       sigma_multiplier,
  input  psod_pkg::ctrl_word_t           ctrl,
  output psod_pkg::status_t              status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_same_address,
  output logic                           out_oversize,
  output logic                           out_outlier
);
  import psod_pkg::*;

  // Window state.
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [SUM_W-1:0]   s_r, s_nxt;
  logic [SQ_W-1:0]    q_r, q_nxt;
  logic               evict_r, evict_nxt;

  // Item and scratch registers.
  logic [LEN_W-1:0]   len_r;
  logic               same_r;
  logic               over_r;
  logic [P_W-1:0]     p_r, p_nxt;
  logic [SUM_W-1:0]   dev_r, dev_nxt;
  logic [VAR_W-1:0]   t_r, t_nxt;
  logic [VAR_W-1:0]   lhs_r, lhs_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_same_r, out_same_nxt;
  logic               out_over_r, out_over_nxt;
  logic               out_outl_r, out_outl_nxt;

  logic [LEN_W-1:0]   old_len;
  logic               full;
  logic               out_free;
  logic               result_load;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_full;
  logic [P_W-1:0]     s_ext;

  // Ring of the last lengths; the oldest entry is read at the read step, before the commit step replaces it.
  psod_ram #(
    .WIDTH (LEN_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ctrl.commit),
    .waddr (wp_r),
    .wdata (len_r),
    .re    (ctrl.ram_rd),
    .raddr (wp_r),
    .rdata (old_len)
  );

  assign full        = (n_r == FULL_COUNT);
  assign out_free    = !out_valid_r || out_ready;
  assign result_load = (ctrl.acc_op == ACC_CMP) && out_free;
  assign status      = '{out_free: out_free, window_full: full};

  // Operand steering for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_LEN_LEN: begin
        mul_a = MUL_A_W'(len_r);
        mul_b = MUL_B_W'(len_r);
      end
      MUL_OLD_OLD: begin
        mul_a = MUL_A_W'(old_len);
        mul_b = MUL_B_W'(old_len);
      end
      MUL_N_LEN: begin
        mul_a = MUL_A_W'(len_r);
        mul_b = MUL_B_W'(n_r);
      end
      MUL_N_Q: begin
        mul_a = MUL_A_W'(q_r);
        mul_b = MUL_B_W'(n_r);
      end
      MUL_S_S: begin
        mul_a = MUL_A_W'(s_r);
        mul_b = MUL_B_W'(s_r);
      end
      MUL_DEV_DEV: begin
        mul_a = MUL_A_W'(dev_r);
        mul_b = MUL_B_W'(dev_r);
      end
      MUL_K_K: begin
        mul_a = MUL_A_W'(sigma_multiplier);
        mul_b = MUL_B_W'(sigma_multiplier);
      end
      MUL_K2_VAR: begin
        mul_a = t_r;
        mul_b = MUL_B_W'(p_r[K2_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Every product used here fits the product register, so the top bits are dropped.
  assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign p_nxt    = (ctrl.mul_sel == MUL_NONE) ? p_r : mul_full[P_W-1:0];
  assign s_ext    = P_W'(s_r);

  // Window update on the commit step: store the length, move the pointer, fix the sum.
  always_comb begin
    wp_nxt    = wp_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    evict_nxt = evict_r;
    if (ctrl.commit) begin
      wp_nxt    = (wp_r == LAST_PTR) ? '0 : wp_r + PTR_W'(1);
      n_nxt     = full ? n_r : n_r + CNT_W'(1);
      s_nxt     = s_r + SUM_W'(len_r) - (full ? SUM_W'(old_len) : '0);
      evict_nxt = full;
    end
  end

  // Accumulate and scratch operations on the previous product.
  always_comb begin
    q_nxt   = q_r;
    dev_nxt = dev_r;
    t_nxt   = t_r;
    lhs_nxt = lhs_r;
    case (ctrl.acc_op)
      ACC_ADD_SQ: begin
        q_nxt = q_r + SQ_W'(p_r);
      end
      ACC_SUB_SQ: begin
        if (evict_r) begin
          q_nxt = q_r - SQ_W'(p_r);
        end
      end
      ACC_DEV: begin
        dev_nxt = (p_r >= s_ext) ? SUM_W'(p_r - s_ext) : SUM_W'(s_ext - p_r);
      end
      ACC_LOAD_T: begin
        t_nxt = VAR_W'(p_r);
      end
      ACC_SUB_T: begin
        t_nxt = t_r - VAR_W'(p_r);
      end
      ACC_LOAD_L: begin
        lhs_nxt = VAR_W'(p_r);
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  // Result register: loaded at the decide step, emptied when the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_same_nxt  = out_same_r;
    out_over_nxt  = out_over_r;
    out_outl_nxt  = out_outl_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (result_load) begin
      out_valid_nxt = 1'b1;
      out_same_nxt  = same_r;
      out_over_nxt  = over_r;
      out_outl_nxt  = P_W'(lhs_r) > p_r;
    end
  end

  // Control state and window sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      n_r         <= '0;
      s_r         <= '0;
      q_r         <= '0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      n_r         <= n_nxt;
      s_r         <= s_nxt;
      q_r         <= q_nxt;
      evict_r     <= evict_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    if (start) begin
      len_r  <= packet_length;
      same_r <= (src_address == dst_address);
      over_r <= (packet_length > oversize_limit);
    end
    p_r        <= p_nxt;
    dev_r      <= dev_nxt;
    t_r        <= t_nxt;
    lhs_r      <= lhs_nxt;
    out_same_r <= out_same_nxt;
    out_over_r <= out_over_nxt;
    out_outl_r <= out_outl_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_same_address = out_same_r;
  assign out_oversize     = out_over_r;
  assign out_outlier      = out_outl_r;

endmodule

>>> sv/packet_size_outlier_detector.sv
// Top level of the packet size outlier detector: configuration registers and wiring.
//
//   Channel   Direction  Carries                                               Handshake
//   in_ch     sink       ip_version, src_address, dst_address, packet_length   valid/ready
//   out_ch    source     same_address, oversize, outlier                       valid/ready
//   cfg_*     slave      oversize_limit (addr 0), sigma_multiplier (addr 4)    APB, pready high
//
// An IPv4 word occupies the block from acceptance to the next acceptance: the accept cycle and
// nine program steps; each step but the last starts one product of the shared multiplier.
// A word of any other version is taken while the sequencer is idle and gives no result.
// The last step waits while the result register still holds an untaken word.
// Reset is synchronous and empties the window; the ring needs no clearing pass.
module packet_size_outlier_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  psod_in_if.sink                           in_ch,
  psod_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [psod_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [psod_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [psod_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import psod_pkg::*;

  logic [LEN_W-1:0]     limit_r, limit_nxt;
  logic [K_W-1:0]       sigma_r, sigma_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;
  logic                 busy;
  logic                 start;
  ctrl_word_t           ctrl;
  status_t              status;

  // Register file access.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    limit_nxt = limit_r;
    sigma_nxt = sigma_r;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_OVERSIZE_LIMIT: limit_nxt = cfg_pwdata[LEN_W-1:0];
        REG_SIGMA:          sigma_nxt = cfg_pwdata[K_W-1:0];
        default:            limit_nxt = limit_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OVERSIZE_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r);
      REG_SIGMA:          cfg_prdata = CFG_DATA_W'(sigma_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      sigma_r <= SIGMA_RESET;
    end else begin
      limit_r <= limit_nxt;
      sigma_r <= sigma_nxt;
    end
  end

  // Words are taken whenever the sequencer is idle; only IPv4 words start the program.
  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && in_ch.ready && (in_ch.ip_version == IPV4);

  psod_ucode u_ucode (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  psod_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .src_address      (in_ch.src_address),
    .dst_address      (in_ch.dst_address),
    .packet_length    (in_ch.packet_length),
    .oversize_limit   (limit_r),
    .sigma_multiplier (sigma_r),
    .ctrl             (ctrl),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_same_address (out_ch.same_address),
    .out_oversize     (out_ch.oversize),
    .out_outlier      (out_ch.outlier)
  );

endmodule

>>> sv/psod_checker.sv
// Port-level checker for the packet size outlier detector and its bind statement.
module psod_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_same_address,
  input logic out_oversize,
  input logic out_outlier
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its flags.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_same_address) && $stable(out_oversize) &&
                                $stable(out_outlier))
    else $error("result word changed while stalled");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // No result can follow the very next cycle after a word is taken into an idle block.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after acceptance");

  // A new result appears only as the sequencer goes idle, so the input side is open.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while the sequencer is still busy");

endmodule

bind packet_size_outlier_detector psod_checker u_psod_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_same_address (out_ch.same_address),
  .out_oversize     (out_ch.oversize),
  .out_outlier      (out_ch.outlier)
);

>>> tb/sv/psod_flag_checker.sv
// Passive checker: tracks the registers, predicts the flags of each packet word, compares results.
module psod_flag_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  psod_in_if                              in_ch,
  psod_out_if                             out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [psod_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [psod_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              mismatch_count,
  output int                              pending_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import psod_pkg::*;

  typedef struct packed {
    logic same_address;
    logic oversize;
    logic outlier;
  } flags_t;

  // Expected flags of accepted IPv4 words, oldest first.
  flags_t expected_flags[$];
  flags_t want;
  int     flag_errors;

  // Register copies as last written on the configuration port.
  logic [LEN_W-1:0] limit_reg;
  logic [K_W-1:0]   sigma_reg;

  // Sliding window of lengths with its running sums.
  logic [LEN_W-1:0] len_hist [WINDOW];
  int               win_ptr;
  int               win_fill;
  bit [63:0]        win_sum;
  bit [63:0]        win_sq_sum;

  // Push one length into the window and work out the three flags of the word.
  function automatic flags_t predict_flags(input logic [IPADDR_W-1:0] src,
                                           input logic [IPADDR_W-1:0] dst,
                                           input logic [LEN_W-1:0]    len);
    flags_t    f;
    bit [63:0] old_len;
    bit [63:0] cur_len;
    bit [63:0] n;
    bit [63:0] n_len;
    bit [63:0] deviation;
    bit [63:0] spread;
    bit [63:0] k_sq;
    cur_len = 64'(len);
    if (win_fill >= WINDOW) begin
      old_len    = 64'(len_hist[win_ptr]);
      win_sum    = win_sum - old_len;
      win_sq_sum = win_sq_sum - old_len * old_len;
    end else begin
      win_fill++;
    end
    len_hist[win_ptr] = len;
    win_sum    = win_sum + cur_len;
    win_sq_sum = win_sq_sum + cur_len * cur_len;
    win_ptr    = (win_ptr == WINDOW - 1) ? 0 : win_ptr + 1;

    // Exact test: (n*len - S)^2 > k^2 * (n*Q - S^2).
    n         = 64'(win_fill);
    n_len     = n * cur_len;
    deviation = (n_len >= win_sum) ? n_len - win_sum : win_sum - n_len;
    spread    = n * win_sq_sum - win_sum * win_sum;
    k_sq      = 64'(sigma_reg) * 64'(sigma_reg);

    f.same_address = (src == dst);
    f.oversize     = (len > limit_reg);
    f.outlier      = (deviation * deviation > k_sq * spread);
    return f;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_flags.delete();
      win_ptr     = 0;
      win_fill    = 0;
      win_sum     = '0;
      win_sq_sum  = '0;
      limit_reg   = LIMIT_RESET;
      sigma_reg   = SIGMA_RESET;
      flag_errors = 0;
    end else begin
      // Results first: a word accepted on this edge cannot have its result out yet.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_flags.size() == 0) begin
          flag_errors++;
          $display("%0t: unexpected result word: expected none, actual %03b",
                   $time, {out_ch.same_address, out_ch.oversize, out_ch.outlier});
        end else begin
          want = expected_flags.pop_front();
          if (out_ch.same_address !== want.same_address || out_ch.oversize !== want.oversize ||
              out_ch.outlier !== want.outlier) begin
            flag_errors++;
            $display("%0t: flags mismatch (same, oversize, outlier): expected %03b, actual %03b",
                     $time, want, {out_ch.same_address, out_ch.oversize, out_ch.outlier});
          end
        end
      end

      // Register writes complete on the access cycle.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[CFG_ADDR_W-1:2] == REG_OVERSIZE_LIMIT) begin
          limit_reg = cfg_pwdata[LEN_W-1:0];
        end else if (cfg_paddr[CFG_ADDR_W-1:2] == REG_SIGMA) begin
          sigma_reg = cfg_pwdata[K_W-1:0];
        end
      end

      // Only IPv4 words touch the window and give a result.
      if (in_ch.valid && in_ch.ready && in_ch.ip_version == IPV4) begin
        expected_flags.insert(expected_flags.size(),
                              predict_flags(in_ch.src_address, in_ch.dst_address,
                                            in_ch.packet_length));
      end
    end
    mismatch_count <= flag_errors;
    pending_words  <= expected_flags.size();
  end

endmodule

>>> tb/sv/tb_packet_size_outlier_detector.sv
// Testbench top: clock, reset, packet word stimulus, result back-pressure and the verdict.
module tb_packet_size_outlier_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import psod_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 104;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_SETTLE    = 16;
  localparam int TIMEOUT_CYCLES  = 400_000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int pending_words;

  // Idling knobs, in percent of cycles.
  int sender_idle_pct;
  int stall_pct;

  // Long receiver hold-off, requested by the stimulus and counted by the receiver.
  int hold_requested;
  int hold_served;
  int hold_left;

  psod_in_if  in_ch ();
  psod_out_if out_ch ();

  packet_size_outlier_detector DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  psod_flag_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  initial begin
    #(4 * TIMEOUT_CYCLES);
    $display("** packet_size_outlier_detector: FAILED **");
    $finish;
  end

  // Receiver: random stalls, plus the long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_served  = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requested) begin
        hold_left   = HOLD_CYCLES;
        hold_served = hold_served + 1;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one packet word after a random gap and wait until it is taken.
  task automatic push_word(input logic [IPVER_W-1:0]  ver,
                           input logic [IPADDR_W-1:0] src,
                           input logic [IPADDR_W-1:0] dst,
                           input logic [LEN_W-1:0]    len);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.ip_version    <= ver;
    in_ch.src_address   <= src;
    in_ch.dst_address   <= dst;
    in_ch.packet_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering words and wait until every expected result has come, then let the
  // block finish whatever it still has in hand.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle phase on the port.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [IPVER_W-1:0]  ver;
    logic [IPADDR_W-1:0] src;
    logic [IPADDR_W-1:0] dst;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    limit_val;
    logic [K_W-1:0]      sigma_val;
    int                  phase;
    int                  ipv4_sent;
    int                  base_len;
    int                  spread;
    int                  pick;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.ip_version    = '0;
    in_ch.src_address   = '0;
    in_ch.dst_address   = '0;
    in_ch.packet_length = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    sender_idle_pct     = 0;
    stall_pct           = 0;
    hold_requested      = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings. The first one is alone in the window.
    push_word(IPV4, 32'h0000_0000, 32'h0000_0000, 16'd0);
    push_word(IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    // Non-IPv4 words must leave no trace.
    push_word(4'h0, $urandom(), $urandom(), 16'hFFFF);
    push_word(4'hF, 32'h1234_5678, 32'h1234_5678, 16'd0);
    push_word(4'h6, $urandom(), $urandom(), 16'd1500);
    // Right at and just above the oversize limit.
    push_word(IPV4, 32'h0A00_0001, 32'h0A00_0002, 16'd1500);
    push_word(IPV4, 32'hC0A8_0001, 32'hC0A8_0001, 16'd1501);
    // A steady run, then a spike.
    repeat (8) push_word(IPV4, $urandom(), $urandom(), 16'd64);
    push_word(IPV4, $urandom(), $urandom(), 16'd9000);
    drain_results();

    // A zero multiplier flags anything off the mean.
    apb_write(REG_SIGMA, 32'd0);
    push_word(IPV4, $urandom(), $urandom(), 16'd64);
    push_word(IPV4, $urandom(), $urandom(), 16'd700);
    push_word(IPV4, $urandom(), $urandom(), 16'd64);
    drain_results();

    // Zero limit: only a zero length escapes the oversize flag.
    apb_write(REG_OVERSIZE_LIMIT, 32'd0);
    push_word(IPV4, $urandom(), $urandom(), 16'd0);
    push_word(IPV4, $urandom(), $urandom(), 16'd1);
    drain_results();

    // Largest limit and largest multiplier.
    apb_write(REG_OVERSIZE_LIMIT, 32'h0000_FFFF);
    apb_write(REG_SIGMA, 32'h0000_000F);
    push_word(IPV4, $urandom(), $urandom(), 16'hFFFF);
    push_word(IPV4, $urandom(), $urandom(), 16'd0);
    push_word(IPV4, $urandom(), $urandom(), 16'd64);

    // Random phases, each with its own settings, length cluster and idling pattern.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      base_len = $urandom_range(40, 1500);
      spread   = $urandom_range(0, 200);
      case (phase)
        0: begin
          limit_val = '0;
          sigma_val = '1;
        end
        1: begin
          limit_val = '1;
          sigma_val = '0;
        end
        2: begin
          limit_val = LEN_W'(base_len + spread / 2);
          sigma_val = K_W'(1);
        end
        default: begin
          limit_val = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(65535))
                                               : LEN_W'(base_len + $urandom_range(spread));
          sigma_val = K_W'($urandom_range(4));
        end
      endcase
      // Upper bits of the write data are random and must be dropped.
      apb_write(REG_OVERSIZE_LIMIT, ($urandom() & 32'hFFFF_0000) | CFG_DATA_W'(limit_val));
      apb_write(REG_SIGMA, ($urandom() & 32'hFFFF_FFF0) | CFG_DATA_W'(sigma_val));

      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       <= 0;
        end
        1: begin
          sender_idle_pct = 66;
          stall_pct       <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       <= 66;
        end
        default: begin
          sender_idle_pct = 26;
          stall_pct       <= 26;
        end
      endcase
      // Hold the results back for a while so the block fills up and stalls its input.
      if (phase == HOLD_PHASE) begin
        hold_requested <= hold_requested + 1;
      end

      ipv4_sent = 0;
      while (ipv4_sent < WORDS_PER_PHASE) begin
        src = $urandom();
        dst = ($urandom_range(3) == 0) ? src : $urandom();
        pick = $urandom_range(99);
        if (pick < 75) begin
          len = LEN_W'(base_len + $urandom_range(spread));
        end else if (pick < 90) begin
          len = LEN_W'($urandom_range(65535));
        end else if (pick < 95) begin
          len = '0;
        end else begin
          len = '1;
        end
        if ($urandom_range(99) < 12) begin
          do ver = IPVER_W'($urandom_range(15)); while (ver == IPV4);
        end else begin
          ver       = IPV4;
          ipv4_sent = ipv4_sent + 1;
        end
        push_word(ver, src, dst, len);
      end
    end

    sender_idle_pct = 0;
    stall_pct       <= 0;
    drain_results();

    if (mismatch_count == 0 && pending_words == 0) begin
      $display("** packet_size_outlier_detector: PASSED **");
    end else begin
      $display("** packet_size_outlier_detector: FAILED **");
    end
    $finish;
  end

endmodule
